@@ rtl/core/mersenne_twister_prng_defines.svh @@
// Assertion macros for the MT19937 generator
`ifndef MERSENNE_TWISTER_PRNG_DEFINES_SVH
`define MERSENNE_TWISTER_PRNG_DEFINES_SVH
`ifndef SYNTHESIS
// plain property, checked every clock outside reset
`define MTP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define MTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/mtp_pkg.sv @@
// Constants and word functions shared by the MT19937 generator files
`default_nettype none
package mtp_pkg;
	localparam int WORD_W            = 32;
	localparam int STATE_DEPTH_DEF   = 624;
	localparam int MIDDLE_OFFSET_DEF = 397;
	localparam int PADDR_W           = 2;

	localparam logic [PADDR_W-1:0] ADDR_SEED = '0;

	localparam logic [WORD_W-1:0] TWIST_CONST = 32'h9908b0df;
	localparam logic [WORD_W-1:0] INIT_MULT   = 32'd1812433253;
	localparam logic [WORD_W-1:0] TEMPER_B    = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C    = 32'hefc60000;
	localparam logic [WORD_W-1:0] RESET_SEED  = 32'h243f6a88;

	// new state word from the top bit of w[k], w[k+1] and w[k+m]
	function automatic logic [WORD_W-1:0] twist_word(input logic hi,
			input logic [WORD_W-1:0] nxt, input logic [WORD_W-1:0] mid);
		logic [WORD_W-1:0] x;
		x = {hi, nxt[WORD_W-2:0]};
		return mid ^ (x >> 1) ^ (x[0] ? TWIST_CONST : '0);
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/mtp_stream_if.sv @@
// Request and response channels of the MT19937 generator
`default_nettype none
interface mtp_req_if;
	logic valid;
	logic ready;
	logic reseed;

	modport source (output valid, output reseed, input ready);
	modport sink (input valid, input reseed, output ready);
endinterface

interface mtp_rsp_if
	import mtp_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mersenne_twister_prng.sv @@
// MT19937 generator: state memory, seeding and twist sequencer, tempering output stage
// A plain request goes to the fetch state; its tempered word is registered into the output
// once the output register is free, and req.ready is low until then. A request that finds
// the index at the end of the state first twists, one word per cycle through the two-read,
// one-write state memory. A reseed request first refills the state from the seed, then
// twists. After reset the state is filled from the reset seed; req.ready stays low
// meanwhile. Seed writes are taken at any time.
`default_nettype none
`include "mersenne_twister_prng_defines.svh"
module mersenne_twister_prng
	import mtp_pkg::*;
#(
	parameter int STATE_DEPTH   = STATE_DEPTH_DEF,
	parameter int MIDDLE_OFFSET = MIDDLE_OFFSET_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mtp_req_if.sink                req,
	mtp_rsp_if.source              rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [WORD_W-1:0] pwdata,
	output logic      [WORD_W-1:0] prdata,
	output logic                   pready
);
	localparam int ADDR_W = $clog2(STATE_DEPTH);
	localparam int IDX_W  = $clog2(STATE_DEPTH + 1);
	localparam int AW1    = ADDR_W + 1;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_INIT     = 3'd1;
	localparam logic [2:0] ST_TW_PRIME = 3'd2;
	localparam logic [2:0] ST_TW_LOAD  = 3'd3;
	localparam logic [2:0] ST_TW_RUN   = 3'd4;
	localparam logic [2:0] ST_WAIT     = 3'd5;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_DEPTH - 1);
	localparam logic [IDX_W-1:0]  IDX_END   = IDX_W'(STATE_DEPTH);
	localparam logic [AW1-1:0]    DEPTH_X   = AW1'(STATE_DEPTH);

	logic [WORD_W-1:0] mem [STATE_DEPTH];

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] k_q;
	logic [IDX_W-1:0]  idx_q;
	logic              pend_q;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] p_q;
	logic              cur_hi_q;
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;

	logic              mem_we;
	logic [WORD_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic [WORD_W-1:0] init_next;
	logic [AW1-1:0]    nxt2_raw;
	logic [AW1-1:0]    mid1_raw;
	logic [ADDR_W-1:0] nxt2;
	logic [ADDR_W-1:0] mid1;
	logic              idx_in_range;
	logic              req_acc;
	logic              out_load;
	logic              cfg_wr;

	assign req_acc      = req.valid && req.ready;
	assign req.ready    = (state_q == ST_IDLE);
	assign idx_in_range = (idx_q < IDX_END);
	assign out_load     = (state_q == ST_WAIT) && (!out_valid_q || rsp.ready);
	assign rsp.valid       = out_valid_q;
	assign rsp.random_word = out_word_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == ADDR_SEED) ? seed_q : '0;

	// seeding recurrence: one multiply and add per word
	assign init_next = WORD_W'(INIT_MULT * (p_q ^ (p_q >> 30))) + WORD_W'(k_q);

	// read addresses for twist step k+1, wrapped at the state end
	assign nxt2_raw = AW1'(k_q) + AW1'(2);
	assign mid1_raw = AW1'(k_q) + AW1'(1 + MIDDLE_OFFSET);
	assign nxt2 = (nxt2_raw >= DEPTH_X) ? ADDR_W'(nxt2_raw - DEPTH_X) : ADDR_W'(nxt2_raw);
	assign mid1 = (mid1_raw >= DEPTH_X) ? ADDR_W'(mid1_raw - DEPTH_X) : ADDR_W'(mid1_raw);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = init_next;
		rd_addr_a = '0;
		rd_addr_b = '0;
		case (state_q)
			ST_IDLE, ST_WAIT: begin
				rd_addr_a = idx_in_range ? idx_q[ADDR_W-1:0] : '0;
			end
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = (k_q == '0) ? seed_q : init_next;
			end
			ST_TW_PRIME: begin
				rd_addr_a = '0;
			end
			ST_TW_LOAD: begin
				rd_addr_a = ADDR_W'(1);
				rd_addr_b = ADDR_W'(MIDDLE_OFFSET);
			end
			ST_TW_RUN: begin
				mem_we    = 1'b1;
				mem_wdata = twist_word(cur_hi_q, rd_a_q, rd_b_q);
				// on the last step fetch word 0 for the draw that follows
				rd_addr_a = (k_q == LAST_ADDR) ? '0 : nxt2;
				rd_addr_b = mid1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[k_q] <= mem_wdata;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			p_q <= mem_wdata;
		end
		if (state_q == ST_TW_LOAD || state_q == ST_TW_RUN) begin
			cur_hi_q <= rd_a_q[WORD_W-1];
		end
		if (out_load) begin
			out_word_q <= temper(rd_a_q);
		end
	end

	// drop writes to any address but the seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= RESET_SEED;
		end else if (cfg_wr && paddr == ADDR_SEED) begin
			seed_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			k_q     <= '0;
			idx_q   <= IDX_END;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.reseed) begin
							pend_q  <= 1'b1;
							k_q     <= '0;
							state_q <= ST_INIT;
						end else if (!idx_in_range) begin
							state_q <= ST_TW_PRIME;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_INIT: begin
					if (k_q == LAST_ADDR) begin
						k_q     <= '0;
						idx_q   <= IDX_END;
						pend_q  <= 1'b0;
						state_q <= pend_q ? ST_TW_PRIME : ST_IDLE;
					end else begin
						k_q <= k_q + ADDR_W'(1);
					end
				end
				ST_TW_PRIME: begin
					k_q     <= '0;
					state_q <= ST_TW_LOAD;
				end
				ST_TW_LOAD: begin
					state_q <= ST_TW_RUN;
				end
				ST_TW_RUN: begin
					if (k_q == LAST_ADDR) begin
						k_q     <= '0;
						idx_q   <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + ADDR_W'(1);
					end
				end
				ST_WAIT: begin
					// hold the fetched word until the output register frees
					if (out_load) begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MTP_ASSERT(a_idx_bound, clk, arst_n, idx_q <= IDX_END, "read index beyond state end")
	`MTP_ASSERT(a_we_phase, clk, arst_n, !mem_we || state_q == ST_INIT || state_q == ST_TW_RUN, "state write outside seeding or twist")
	`MTP_ASSERT(a_no_overwrite, clk, arst_n, !out_load || !out_valid_q || rsp.ready, "output word overwritten before taken")
	`MTP_ASSERT_NEXT(a_plain_draw, clk, arst_n, req_acc && !req.reseed && idx_in_range, state_q == ST_WAIT, "plain draw did not go to fetch")
	`MTP_ASSERT_NEXT(a_twist_end, clk, arst_n, state_q == ST_TW_RUN && k_q == LAST_ADDR, idx_q == '0 && state_q == ST_WAIT, "twist did not restart index")
endmodule
`default_nettype wire
